FILE: rtl/dpo_pkg.sv
package dpo_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_IMAGE_SCALE = 3'd0;
  localparam logic [2:0] REG_CROP_X      = 3'd1;
  localparam logic [2:0] REG_CROP_Y      = 3'd2;
  localparam logic [2:0] REG_XZ_FACTOR   = 3'd3;
  localparam logic [2:0] REG_YZ_FACTOR   = 3'd4;
  localparam logic [2:0] REG_COEFF_X     = 3'd5;
  localparam logic [2:0] REG_COEFF_Y     = 3'd6;

  // Reset values of the registers.
  localparam logic [15:0] RST_IMAGE_SCALE = 16'd256;
  localparam logic [15:0] RST_XZ_FACTOR   = 16'd18432;
  localparam logic [15:0] RST_YZ_FACTOR   = 16'd13824;
  localparam logic [15:0] RST_COEFF       = 16'd9102;

  // Numerator widths of the two divider pipelines.
  localparam int DIV1_NW = 41;
  localparam int DIV2_NW = 33;

  // Edges from accepting an item to the first edge that sees its result strobe:
  // four stages ahead of the depth divider, four between the dividers and
  // the output register.
  localparam int DPO_LAT = 4 + DIV1_NW + 4 + DIV2_NW + 1;

  // Configuration seen by one axis.
  typedef struct packed {
    logic [15:0] scale;
    logic [9:0]  crop;
    logic [15:0] factor;
    logic [15:0] coeff;
  } axis_cfg_t;

endpackage

FILE: rtl/dpo_div_pipe.sv
module dpo_div_pipe import dpo_pkg::*; #(
  parameter int NW = 41,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [15:0]   in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  // One quotient bit per stage, restoring division.
  logic          vld_r  [NW];
  logic [15:0]   rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [15:0]   den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          cur_vld;
    logic [15:0]   cur_rem;
    logic [NW-1:0] cur_num;
    logic [NW-1:0] cur_quo;
    logic [15:0]   cur_den;
    logic [SW-1:0] cur_side;
    logic [16:0]   trial;
    logic [16:0]   diff;
    logic          qbit;

    if (i == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_rem  = '0;
      assign cur_num  = in_num;
      assign cur_quo  = '0;
      assign cur_den  = in_den;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld_r[i-1];
      assign cur_rem  = rem_r[i-1];
      assign cur_num  = num_r[i-1];
      assign cur_quo  = quo_r[i-1];
      assign cur_den  = den_r[i-1];
      assign cur_side = side_r[i-1];
    end

    // Shift in the next numerator bit and try the subtraction.
    assign trial = {cur_rem, cur_num[NW-1]};
    assign diff  = trial - {1'b0, cur_den};
    assign qbit  = (trial >= {1'b0, cur_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= qbit ? diff[15:0] : trial[15:0];
      num_r[i]  <= cur_num << 1;
      quo_r[i]  <= {cur_quo[NW-2:0], qbit};
      den_r[i]  <= cur_den;
      side_r[i] <= cur_side;
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_quo  = quo_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

FILE: rtl/dpo_axis.sv
module dpo_axis import dpo_pkg::*; #(
  parameter int RES      = 640,
  parameter bit VERTICAL = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] in_pix,
  input  logic signed [15:0] in_shift,
  input  logic [15:0]        in_depth,
  input  logic               in_bypass,
  input  axis_cfg_t          cfg,
  output logic               out_vld,
  output logic signed [15:0] out_val
);

  localparam logic signed [35:0] CENTER   = 36'(128 * RES);
  localparam logic signed [63:0] HALF     = 64'(RES) <<< 15;
  // Reciprocal of the resolution, ceil(2^52 / RES). It gives the exact floor
  // for the 40-bit scaled numerator and is split into two narrow factors.
  localparam logic [63:0]        RECIP    = ((64'd1 << 52) + 64'(RES) - 64'd1) / 64'(RES);
  localparam logic [23:0]        RECIP_LO = RECIP[23:0];
  localparam logic [24:0]        RECIP_HI = RECIP[48:24];

  // Stage 1: full-resolution coordinate and shift times coefficient.
  logic signed [17:0] sum_c;
  logic signed [16:0] sh_ext;
  logic [16:0]        sh_mag;
  logic               s1_vld_r;
  logic signed [34:0] full_r;
  logic [32:0]        cs_r;
  logic               sb1_r;
  logic [15:0]        dep1_r;
  logic               byp1_r;
  logic signed [15:0] pix1_r;

  assign sum_c  = {{2{in_pix[15]}}, in_pix} + $signed({8'b0, cfg.crop});
  assign sh_ext = {in_shift[15], in_shift};
  assign sh_mag = sh_ext[16] ? 17'(-sh_ext) : 17'(sh_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    full_r <= sum_c * $signed({1'b0, cfg.scale});
    cs_r   <= {16'b0, sh_mag} * {17'b0, cfg.coeff};
    sb1_r  <= in_shift[15];
    dep1_r <= in_depth;
    byp1_r <= in_bypass;
    pix1_r <= in_pix;
  end

  // Stage 2: centered coordinate, split into sign and magnitude.
  logic signed [35:0] num_c;
  logic [35:0]        nmag_c;
  logic               s2_vld_r;
  logic [31:0]        nmag2_r;
  logic [40:0]        db_num2_r;
  logic               nsg2_r;
  logic               sb2_r;
  logic [15:0]        dep2_r;
  logic               byp2_r;
  logic signed [15:0] pix2_r;

  assign num_c  = VERTICAL ? (CENTER - 36'(full_r)) : (36'(full_r) - CENTER);
  assign nmag_c = num_c[35] ? 36'(-num_c) : 36'(num_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    nmag2_r   <= nmag_c[31:0];
    db_num2_r <= {cs_r, 8'b0};
    nsg2_r    <= num_c[35];
    sb2_r     <= sb1_r;
    dep2_r    <= dep1_r;
    byp2_r    <= byp1_r;
    pix2_r    <= pix1_r;
  end

  // Stage 3: partial products of the magnitude with the reciprocal.
  logic               s3_vld_r;
  logic [55:0]        plo3_r;
  logic [56:0]        phi3_r;
  logic [40:0]        db_num3_r;
  logic               nsg3_r;
  logic               sb3_r;
  logic [15:0]        dep3_r;
  logic               byp3_r;
  logic signed [15:0] pix3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    plo3_r    <= 56'(nmag2_r) * 56'(RECIP_LO);
    phi3_r    <= 57'(nmag2_r) * 57'(RECIP_HI);
    db_num3_r <= db_num2_r;
    nsg3_r    <= nsg2_r;
    sb3_r     <= sb2_r;
    dep3_r    <= dep2_r;
    byp3_r    <= byp2_r;
    pix3_r    <= pix2_r;
  end

  // Stage 4: normalized coordinate magnitude, floor(256 * |num| / RES).
  logic [80:0]        prod_c;
  logic               s4_vld_r;
  logic [36:0]        nq4_r;
  logic [40:0]        db_num4_r;
  logic               nsg4_r;
  logic               sb4_r;
  logic [15:0]        dep4_r;
  logic               byp4_r;
  logic signed [15:0] pix4_r;

  assign prod_c = {phi3_r, 24'b0} + 81'(plo3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    nq4_r     <= prod_c[80:44];
    db_num4_r <= db_num3_r;
    nsg4_r    <= nsg3_r;
    sb4_r     <= sb3_r;
    dep4_r    <= dep3_r;
    byp4_r    <= byp3_r;
    pix4_r    <= pix3_r;
  end

  // Shift term over the depth; the coordinate rides along on the side bits.
  logic               db_vld;
  logic [40:0]        db_quo;
  logic [55:0]        db_side;

  dpo_div_pipe #(.NW(DIV1_NW), .SW(56)) u_div_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_num   (db_num4_r),
    .in_den   (dep4_r),
    .in_side  ({byp4_r, pix4_r, nsg4_r, sb4_r, nq4_r}),
    .out_vld  (db_vld),
    .out_quo  (db_quo),
    .out_side (db_side)
  );

  // Stage 5: apply the pinhole factor to the magnitude, sign the shift term.
  logic               s5_vld_r;
  logic [52:0]        pt5_r;
  logic signed [41:0] b5_r;
  logic               nsg5_r;
  logic               byp5_r;
  logic signed [15:0] pix5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= db_vld;
    end
  end

  always_ff @(posedge clk) begin
    pt5_r  <= 53'(db_side[36:0]) * 53'(cfg.factor);
    b5_r   <= db_side[37] ? -$signed({1'b0, db_quo}) : $signed({1'b0, db_quo});
    nsg5_r <= db_side[38];
    pix5_r <= db_side[54:39];
    byp5_r <= db_side[55];
  end

  // Stage 6: truncate the factor product and apply the coefficient.
  // Magnitudes are floored here, which truncates toward zero once signed.
  logic               s6_vld_r;
  logic [54:0]        pa6_r;
  logic signed [41:0] b6_r;
  logic               nsg6_r;
  logic               byp6_r;
  logic signed [15:0] pix6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pa6_r  <= 55'(pt5_r[52:14]) * 55'(cfg.coeff);
    b6_r   <= b5_r;
    nsg6_r <= nsg5_r;
    byp6_r <= byp5_r;
    pix6_r <= pix5_r;
  end

  // Stage 7: sign the projected term and add the shift and the image center.
  logic [63:0]        a_mag;
  logic signed [63:0] a_c;
  logic signed [63:0] ab_c;
  logic signed [63:0] u_c;
  logic               s7_vld_r;
  logic signed [63:0] u7_r;
  logic               byp7_r;
  logic signed [15:0] pix7_r;

  assign a_mag = 64'(pa6_r[54:4]);
  assign a_c   = nsg6_r ? -$signed(a_mag) : $signed(a_mag);
  assign ab_c  = a_c + 64'(b6_r);
  assign u_c   = VERTICAL ? (HALF - ab_c) : (ab_c + HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    u7_r   <= u_c;
    byp7_r <= byp6_r;
    pix7_r <= pix6_r;
  end

  // Stage 8: undo crop and scale up to the final division.
  logic signed [63:0] cs_off;
  logic signed [63:0] m_c;
  logic [63:0]        mmag_c;
  logic               s8_vld_r;
  logic [47:0]        mq8_r;
  logic               msg8_r;
  logic               byp8_r;
  logic signed [15:0] pix8_r;

  assign cs_off = $signed({22'b0, ({16'b0, cfg.crop} * {10'b0, cfg.scale}), 16'b0});
  assign m_c    = (u7_r <<< 8) - cs_off;
  assign mmag_c = m_c[63] ? 64'(-m_c) : 64'(m_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else begin
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mq8_r  <= mmag_c[63:16];
    msg8_r <= m_c[63];
    byp8_r <= byp7_r;
    pix8_r <= pix7_r;
  end

  // Final division by the scale; a quotient of 2^17 or more saturates anyway.
  logic        sat_c;
  logic        df_vld;
  logic [32:0] df_quo;
  logic [18:0] df_side;

  assign sat_c = (mq8_r >= {15'b0, cfg.scale, 17'b0});

  dpo_div_pipe #(.NW(DIV2_NW), .SW(19)) u_div_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s8_vld_r),
    .in_num   (mq8_r[32:0]),
    .in_den   (cfg.scale),
    .in_side  ({byp8_r, pix8_r, msg8_r, sat_c}),
    .out_vld  (df_vld),
    .out_quo  (df_quo),
    .out_side (df_side)
  );

  // Output stage: sign, saturation and pass-through.
  logic               big_c;
  logic [16:0]        mag_c;
  logic signed [15:0] val_c;
  logic               out_vld_r;
  logic signed [15:0] out_val_r;

  assign big_c = df_side[0] | (|df_quo[32:17]);
  assign mag_c = df_quo[16:0];

  always_comb begin
    if (df_side[18]) begin
      val_c = df_side[17:2];
    end else if (df_side[1]) begin
      val_c = (big_c || mag_c > 17'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, mag_c}));
    end else begin
      val_c = (big_c || mag_c > 17'd32767) ? 16'sd32767 : $signed(mag_c[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= df_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= val_c;
  end

  assign out_vld = out_vld_r;
  assign out_val = out_val_r;

endmodule

FILE: rtl/depth_pixel_offset_by_mm.sv
// Channel   Handshake                   Payload
// input     start / busy                in_pixel_x, in_pixel_y, in_shift_x_mm,
//                                       in_shift_y_mm, in_depth_mm
// result    out_valid (one-cycle)       out_moved_x, out_moved_y
// config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One item is taken every clock cycle; busy stays low.
// Each result strobes out_valid once its item has passed the 41-stage depth divider
// and the 33-stage scale divider, which compute one bit per stage.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults. The receiver cannot stall, so nothing ever waits.
module depth_pixel_offset_by_mm import dpo_pkg::*; #(
  parameter int RES_X = 640,
  parameter int RES_Y = 480
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_pixel_x,
  input  logic signed [15:0] in_pixel_y,
  input  logic signed [15:0] in_shift_x_mm,
  input  logic signed [15:0] in_shift_y_mm,
  input  logic [15:0]        in_depth_mm,
  output logic               out_valid,
  output logic signed [15:0] out_moved_x,
  output logic signed [15:0] out_moved_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Configuration registers.
  logic [15:0] image_scale_r;
  logic [9:0]  crop_x_r;
  logic [9:0]  crop_y_r;
  logic [15:0] xz_factor_r;
  logic [15:0] yz_factor_r;
  logic [15:0] coeff_x_r;
  logic [15:0] coeff_y_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_scale_r <= RST_IMAGE_SCALE;
      crop_x_r      <= '0;
      crop_y_r      <= '0;
      xz_factor_r   <= RST_XZ_FACTOR;
      yz_factor_r   <= RST_YZ_FACTOR;
      coeff_x_r     <= RST_COEFF;
      coeff_y_r     <= RST_COEFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_SCALE: image_scale_r <= cfg_data;
        REG_CROP_X:      crop_x_r      <= cfg_data[9:0];
        REG_CROP_Y:      crop_y_r      <= cfg_data[9:0];
        REG_XZ_FACTOR:   xz_factor_r   <= cfg_data;
        REG_YZ_FACTOR:   yz_factor_r   <= cfg_data;
        REG_COEFF_X:     coeff_x_r     <= cfg_data;
        REG_COEFF_Y:     coeff_y_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item acceptance and pass-through decision.
  logic      acc;
  logic      bypass;
  axis_cfg_t cfg_x;
  axis_cfg_t cfg_y;
  logic      vld_x;
  logic      vld_y;

  assign acc    = start & ~busy;
  assign bypass = (in_depth_mm == 16'd0) | (image_scale_r == 16'd0);
  assign cfg_x  = '{scale: image_scale_r, crop: crop_x_r, factor: xz_factor_r,
                    coeff: coeff_x_r};
  assign cfg_y  = '{scale: image_scale_r, crop: crop_y_r, factor: yz_factor_r,
                    coeff: coeff_y_r};

  dpo_axis #(.RES(RES_X), .VERTICAL(1'b0)) u_axis_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (acc),
    .in_pix    (in_pixel_x),
    .in_shift  (in_shift_x_mm),
    .in_depth  (in_depth_mm),
    .in_bypass (bypass),
    .cfg       (cfg_x),
    .out_vld   (vld_x),
    .out_val   (out_moved_x)
  );

  dpo_axis #(.RES(RES_Y), .VERTICAL(1'b1)) u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (acc),
    .in_pix    (in_pixel_y),
    .in_shift  (in_shift_y_mm),
    .in_depth  (in_depth_mm),
    .in_bypass (bypass),
    .cfg       (cfg_y),
    .out_vld   (vld_y),
    .out_val   (out_moved_y)
  );

  assign out_valid = vld_x;

`ifndef SYNTHESIS
  // Both axis pipelines stay in step.
  a_axes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    vld_x == vld_y) else $error("axis pipelines out of step");

  // Every accepted item yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##DPO_LAT out_valid) else $error("result missing after latency");

  // No result appears without an item behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, DPO_LAT)) else $error("result without item");
`endif

endmodule

FILE: dv/depth_pixel_offset_by_mm_tb.sv
`timescale 1ns / 100ps

module depth_pixel_offset_by_mm_tb;
  import dpo_pkg::*;

  localparam int RES_X = 640;
  localparam int RES_Y = 480;
  localparam int N_RANDOM = 1530;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_DIRECTED = 20;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_pixel_x;
  logic signed [15:0] in_pixel_y;
  logic signed [15:0] in_shift_x_mm;
  logic signed [15:0] in_shift_y_mm;
  logic [15:0]        in_depth_mm;
  logic               out_valid;
  logic signed [15:0] out_moved_x;
  logic signed [15:0] out_moved_y;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  depth_pixel_offset_by_mm #(.RES_X(RES_X), .RES_Y(RES_Y)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .in_shift_x_mm(in_shift_x_mm), .in_shift_y_mm(in_shift_y_mm),
    .in_depth_mm(in_depth_mm), .out_valid(out_valid),
    .out_moved_x(out_moved_x), .out_moved_y(out_moved_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [15:0]        depth;
  } point_item_t;

  typedef struct packed {
    logic signed [15:0] mx;
    logic signed [15:0] my;
  } moved_pt_t;

  // Directed row: item plus an optional typed-in expectation.
  typedef struct packed {
    point_item_t item;
    logic        has_exp;
    moved_pt_t   exp;
  } dir_row_t;

  // Local copy of the registers.
  logic [15:0] m_scale;
  logic [9:0]  m_crop_x;
  logic [9:0]  m_crop_y;
  logic [15:0] m_xz;
  logic [15:0] m_yz;
  logic [15:0] m_cx;
  logic [15:0] m_cy;

  moved_pt_t pending_moves[$];
  int        err_count;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat_to16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // One axis of unproject, shift and reproject, in 64-bit integers.
  function automatic longint move_axis(longint pix, longint crop, longint scale,
                                       longint factor, longint coeff,
                                       longint shift, longint depth,
                                       longint res, bit vertical);
    longint full, num, n, t, a, b, half, u, den, m;
    full = (pix + crop) * scale;
    num  = vertical ? (128 * res - full) : (full - 128 * res);
    n    = (num * 256) / res;
    t    = (n * factor) / 16384;
    a    = (t * coeff) / 16;
    b    = (coeff * shift * 256) / depth;
    half = res * 32768;
    u    = vertical ? (half - a - b) : (a + b + half);
    den  = scale * 65536;
    m    = u * 256 - crop * den;
    return sat_to16(m / den);
  endfunction

  function automatic moved_pt_t predict_move(point_item_t it);
    moved_pt_t r;
    if (it.depth == 0 || m_scale == 0) begin
      r.mx = it.px;
      r.my = it.py;
    end else begin
      r.mx = 16'(move_axis(longint'(it.px), m_crop_x, m_scale, m_xz, m_cx,
                           longint'(it.sx), it.depth, RES_X, 1'b0));
      r.my = 16'(move_axis(longint'(it.py), m_crop_y, m_scale, m_yz, m_cy,
                           longint'(it.sy), it.depth, RES_Y, 1'b1));
    end
    return r;
  endfunction

  // Result checker and inactivity watchdog.
  always @(posedge clk) begin
    moved_pt_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_moves.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result x=%0d y=%0d", out_moved_x, out_moved_y);
        end else begin
          want = pending_moves.pop_front();
          if (want.mx !== out_moved_x || want.my !== out_moved_y) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       want.mx, want.my, out_moved_x, out_moved_y);
          end
        end
      end
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL depth_pixel_offset_by_mm");
        $finish;
      end
    end
  end

  // Lowers start for a random gap in about one call of three, most gaps short and a few long.
  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 2) == 0) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                        : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drives one item and holds it until it is taken.
  task automatic send_point(point_item_t it, bit gaps);
    in_pixel_x    <= it.px;
    in_pixel_y    <= it.py;
    in_shift_x_mm <= it.sx;
    in_shift_y_mm <= it.sy;
    in_depth_mm   <= it.depth;
    start         <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_moves.push_back(predict_move(it));
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) != 0)
      idle_gap();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_moves.size() != 0) @(negedge clk);
    repeat (DPO_LAT + 8) @(negedge clk);
  endtask

  // Writes one register; the caller lowers cfg_valid after the last write.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_IMAGE_SCALE: m_scale  = val;
      REG_CROP_X:      m_crop_x = val[9:0];
      REG_CROP_Y:      m_crop_y = val[9:0];
      REG_XZ_FACTOR:   m_xz     = val;
      REG_YZ_FACTOR:   m_yz     = val;
      REG_COEFF_X:     m_cx     = val;
      REG_COEFF_Y:     m_cy     = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(logic [15:0] s, logic [9:0] cx, logic [9:0] cy,
                           logic [15:0] fx, logic [15:0] fy,
                           logic [15:0] kx, logic [15:0] ky);
    write_reg(REG_IMAGE_SCALE, s);
    write_reg(REG_CROP_X, {6'($urandom), cx});
    write_reg(REG_CROP_Y, {6'($urandom), cy});
    write_reg(REG_XZ_FACTOR, fx);
    write_reg(REG_YZ_FACTOR, fy);
    write_reg(REG_COEFF_X, kx);
    write_reg(REG_COEFF_Y, ky);
    cfg_valid <= 1'b0;
  endtask

  // Random item: mostly image-sized pixels and realistic depths.
  function automatic point_item_t rand_point();
    point_item_t it;
    int k;
    k = $urandom_range(0, 9);
    it.px = (k < 7) ? 16'($urandom_range(0, 700)) : 16'($urandom);
    it.py = (k < 7) ? 16'($urandom_range(0, 520)) : 16'($urandom);
    it.sx = 16'($urandom);
    it.sy = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       it.depth = 16'd0;
      1:       it.depth = 16'($urandom_range(1, 8));
      2:       it.depth = 16'($urandom);
      default: it.depth = 16'($urandom_range(300, 8000));
    endcase
    return it;
  endfunction

  dir_row_t dir_rows[N_DIRECTED];

  initial begin
    int i;
    int phase;
    point_item_t it;
    moved_pt_t   want;
    err_count    = 0;
    idle_cycles  = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_SCALE;
    cfg_data  = 16'd0;
    in_pixel_x = '0; in_pixel_y = '0; in_shift_x_mm = '0;
    in_shift_y_mm = '0; in_depth_mm = '0;
    m_scale = RST_IMAGE_SCALE; m_crop_x = '0; m_crop_y = '0;
    m_xz = RST_XZ_FACTOR; m_yz = RST_YZ_FACTOR; m_cx = RST_COEFF; m_cy = RST_COEFF;

    // Zero depth passes the pixel through; the rest go to the predictor.
    dir_rows[0]  = '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1, '{16'sd0, 16'sd0}};
    dir_rows[1]  = '{'{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'd0}, 1'b1,
                     '{16'sh7fff, 16'sh8000}};
    dir_rows[2]  = '{'{16'sh8000, 16'sh7fff, 16'sd5, 16'sd5, 16'd0}, 1'b1,
                     '{16'sh8000, 16'sh7fff}};
    dir_rows[3]  = '{'{16'sd320, 16'sd240, 16'sd0, 16'sd0, 16'd1000}, 1'b0, '0};
    dir_rows[4]  = '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1}, 1'b0, '0};
    dir_rows[5]  = '{'{16'sd639, 16'sd479, 16'sh7fff, 16'sh7fff, 16'd1}, 1'b0, '0};
    dir_rows[6]  = '{'{16'sd100, 16'sd100, 16'sh8000, 16'sh8000, 16'd1}, 1'b0, '0};
    dir_rows[7]  = '{'{16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 16'hffff}, 1'b0, '0};
    dir_rows[8]  = '{'{16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'hffff}, 1'b0, '0};
    dir_rows[9]  = '{'{16'sd320, 16'sd240, 16'sd1600, 16'sd1600, 16'd500}, 1'b0, '0};
    dir_rows[10] = '{'{16'sd10, 16'sd470, -16'sd1600, -16'sd800, 16'd2000}, 1'b0, '0};
    dir_rows[11] = '{'{-16'sd1, -16'sd1, 16'sh7fff, 16'sh8000, 16'hffff}, 1'b0, '0};
    dir_rows[12] = '{'{16'sd640, 16'sd480, 16'sd16, 16'sd16, 16'd800}, 1'b0, '0};
    dir_rows[13] = '{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'h5555}, 1'b0, '0};
    dir_rows[14] = '{'{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'haaaa}, 1'b0, '0};
    dir_rows[15] = '{'{16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'd2}, 1'b0, '0};
    dir_rows[16] = '{'{16'sd200, 16'sd300, 16'sh4000, -16'sh4000, 16'd3}, 1'b0, '0};
    dir_rows[17] = '{'{16'sd50, 16'sd60, 16'sd0, 16'sd0, 16'h8000}, 1'b0, '0};
    dir_rows[18] = '{'{16'sd320, 16'sd240, 16'sd16, 16'sd16, 16'd1}, 1'b0, '0};
    dir_rows[19] = '{'{-16'sd300, 16'sd900, -16'sd5000, 16'sd5000, 16'd700}, 1'b0, '0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table, first at reset defaults, then at register extremes.
    for (phase = 0; phase < 2; phase++) begin
      for (i = 0; i < N_DIRECTED; i++) begin
        send_point(dir_rows[i].item, 1'b0);
        if (dir_rows[i].has_exp) begin
          want = pending_moves[pending_moves.size() - 1];
          if (want !== dir_rows[i].exp) begin
            err_count++;
            if (err_count <= 10)
              $display("table row %0d: expected x=%0d y=%0d, predictor x=%0d y=%0d",
                       i, dir_rows[i].exp.mx, dir_rows[i].exp.my, want.mx, want.my);
          end
        end
      end
      wait_drained();
      if (phase == 0)
        write_all(16'hffff, 10'h3ff, 10'h3ff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      else
        write_all(16'd1, 10'd0, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    end
    for (i = 0; i < 5; i++) send_point(rand_point(), 1'b0);
    wait_drained();

    // Random phases over several register settings; each drains before the next setting.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all(RST_IMAGE_SCALE, 10'd0, 10'd0, RST_XZ_FACTOR, RST_YZ_FACTOR,
                     RST_COEFF, RST_COEFF);
        1: write_all(16'd512, 10'd40, 10'd30, RST_XZ_FACTOR, RST_YZ_FACTOR,
                     RST_COEFF, RST_COEFF);
        2: write_all(16'd128, 10'($urandom_range(0, 200)), 10'($urandom_range(0, 200)),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        3: write_all(16'hffff, 10'h3ff, 10'h3ff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        4: write_all(16'd1, 10'd0, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        default: write_all(16'($urandom_range(1, 65535)), 10'($urandom), 10'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      for (i = 0; i < N_RANDOM / 6; i++) begin
        it = rand_point();
        send_point(it, (i % 100) < 70);
      end
      wait_drained();
    end

    if (err_count == 0)
      $display("PASS depth_pixel_offset_by_mm");
    else
      $display("FAIL depth_pixel_offset_by_mm");
    $finish;
  end

endmodule
